>>> src/uer_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the echo ranger
package uer_pkg;

    localparam int TICK_W          = 16;
    localparam int DIST_W          = 10;
    localparam int STAT_W          = 2;
    localparam int IDX_W           = 2;
    localparam int KEY_W           = DIST_W + 1;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = DIST_W;

    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;
    localparam int MEDIAN_SAMPLES  = 3;

    localparam int RESET_MAX_CM    = 400;
    localparam int RANGE_DIV       = 343;
    localparam int LIM_WHOLE       = 58;
    localparam int LIM_FRAC_MUL    = 41478436;
    localparam int LIM_FRAC_SHIFT  = 27;
    localparam int LIM_FRAC_W      = DIST_W + 26;
    localparam int DIST_MUL        = 1124;
    localparam int DIST_SHIFT      = 16;
    localparam int DIST_PROD_W     = TICK_W + 11;
    localparam int NORESP_KEY      = 1024;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIST = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEDIAN   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NORESP  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT      = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [DIST_W-1:0] max_cm;
        logic              median;
        logic [TICK_W-1:0] lim_floor;
        logic [TICK_W-1:0] lim_ceil;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_cm;
        logic [STAT_W-1:0] stat;
    } t_smp_wr;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] dist_cm;
        logic [STAT_W-1:0] stat;
    } t_result;

    // floor(max*20000/343) as max*58 + floor(max*106/343), the latter by reciprocal
    function automatic logic [TICK_W-1:0] lim_floor(input logic [DIST_W-1:0] max_cm);
        logic [LIM_FRAC_W-1:0] frac;
        logic [TICK_W:0]       whole;
        frac  = LIM_FRAC_W'(max_cm) * LIM_FRAC_W'(LIM_FRAC_MUL);
        whole = (TICK_W+1)'(max_cm) * (TICK_W+1)'(LIM_WHOLE);
        return TICK_W'(whole + (TICK_W+1)'(frac >> LIM_FRAC_SHIFT));
    endfunction

    // 343 is coprime to 20000, so the limit is whole only for multiples of 343
    function automatic logic lim_exact(input logic [DIST_W-1:0] max_cm);
        return (max_cm == DIST_W'(0)) || (max_cm == DIST_W'(RANGE_DIV))
            || (max_cm == DIST_W'(2 * RANGE_DIV));
    endfunction

    function automatic logic [DIST_W-1:0] dist_of(input logic [TICK_W-1:0] us);
        logic [DIST_PROD_W-1:0] prod;
        prod = DIST_PROD_W'(us) * DIST_PROD_W'(DIST_MUL);
        return prod[DIST_SHIFT +: DIST_W];
    endfunction

endpackage

>>> src/uer_cfg.sv
`timescale 1ns / 1ps
// configuration registers and precomputed echo limits
module uer_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output uer_pkg::t_cfg                    o_cfg
);
    import uer_pkg::*;

    logic [DIST_W-1:0] r_max_cm;
    logic              r_median;
    logic [TICK_W-1:0] r_lim_floor;
    logic [TICK_W-1:0] r_lim_ceil;
    logic [TICK_W-1:0] n_lim_floor;
    logic [DIST_W-1:0] n_max_cm;

    assign n_max_cm    = DIST_W'(i_cfg_data);
    assign n_lim_floor = lim_floor(n_max_cm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cm    <= DIST_W'(RESET_MAX_CM);
            r_median    <= 1'b0;
            r_lim_floor <= lim_floor(DIST_W'(RESET_MAX_CM));
            r_lim_ceil  <= lim_floor(DIST_W'(RESET_MAX_CM))
                           + TICK_W'(!lim_exact(DIST_W'(RESET_MAX_CM)));
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_DIST: begin
                    r_max_cm    <= n_max_cm;
                    r_lim_floor <= n_lim_floor;
                    r_lim_ceil  <= n_lim_floor + TICK_W'(!lim_exact(n_max_cm));
                end
                CFG_MEDIAN: begin
                    r_median <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.max_cm    = r_max_cm;
    assign o_cfg.median    = r_median;
    assign o_cfg.lim_floor = r_lim_floor;
    assign o_cfg.lim_ceil  = r_lim_ceil;

endmodule

>>> src/uer_median.sv
`timescale 1ns / 1ps
// sample store and middle-of-three selection
module uer_median (
    input  logic                        i_clk,
    input  uer_pkg::t_smp_wr            i_wr,
    output logic [uer_pkg::DIST_W-1:0]  o_sel_dist,
    output logic [uer_pkg::STAT_W-1:0]  o_sel_stat
);
    import uer_pkg::*;

    logic [DIST_W-1:0] r_dist [MEDIAN_SAMPLES];
    logic [STAT_W-1:0] r_stat [MEDIAN_SAMPLES];
    logic [DIST_W-1:0] cur_dist [MEDIAN_SAMPLES];
    logic [STAT_W-1:0] cur_stat [MEDIAN_SAMPLES];
    logic [KEY_W-1:0]  key [MEDIAN_SAMPLES];
    logic [IDX_W-1:0]  mid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_dist[i_wr.idx] <= i_wr.dist_cm;
            r_stat[i_wr.idx] <= i_wr.stat;
        end
    end

    // the sample on the write port counts as stored in its slot, also while the write enable is low
    always_comb begin
        for (int i = 0; i < MEDIAN_SAMPLES; i++) begin
            if (i_wr.idx == IDX_W'(i)) begin
                cur_dist[i] = i_wr.dist_cm;
                cur_stat[i] = i_wr.stat;
            end else begin
                cur_dist[i] = r_dist[i];
                cur_stat[i] = r_stat[i];
            end
            key[i] = (cur_stat[i] == ST_NORESP) ? KEY_W'(NORESP_KEY) : KEY_W'(cur_dist[i]);
        end
    end

    always_comb begin
        if (key[0] <= key[1] && key[0] <= key[2]) begin
            mid = (key[1] <= key[2]) ? IDX_W'(1) : IDX_W'(2);
        end else if (key[1] <= key[0] && key[1] <= key[2]) begin
            mid = (key[0] <= key[2]) ? IDX_W'(0) : IDX_W'(2);
        end else begin
            mid = (key[0] <= key[1]) ? IDX_W'(0) : IDX_W'(1);
        end
    end

    always_comb begin
        case (mid)
            IDX_W'(0): begin
                o_sel_dist = cur_dist[0];
                o_sel_stat = cur_stat[0];
            end
            IDX_W'(1): begin
                o_sel_dist = cur_dist[1];
                o_sel_stat = cur_stat[1];
            end
            default: begin
                o_sel_dist = cur_dist[2];
                o_sel_stat = cur_stat[2];
            end
        endcase
    end

endmodule

>>> src/uer_core.sv
`timescale 1ns / 1ps
// trigger and echo timing sequencer, distance conversion
module uer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_action,
    input  logic               i_echo,
    input  uer_pkg::t_cfg      i_cfg,
    output uer_pkg::t_result   o_res
);
    import uer_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] meas_us;
    logic [DIST_W-1:0] meas_dist;
    logic              finished;
    logic [DIST_W-1:0] m_dist;
    logic [STAT_W-1:0] m_stat;
    logic [IDX_W-1:0]  k;
    logic              last_smp;
    t_smp_wr           smp_wr;
    logic [DIST_W-1:0] sel_dist;
    logic [STAT_W-1:0] sel_stat;

    assign tick_inc  = r_tick + TICK_W'(1);
    assign meas_us   = i_echo ? tick_inc : r_tick;
    assign meas_dist = dist_of(meas_us);
    assign k         = (r_idx < IDX_W'(MEDIAN_SAMPLES)) ? r_idx : IDX_W'(0);
    assign last_smp  = (k == IDX_W'(MEDIAN_SAMPLES - 1));

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_idx    = r_idx;
        finished = 1'b0;
        m_dist   = '0;
        m_stat   = ST_OK;
        if (i_action) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_TRIG_LOW;
                n_tick  = '0;
                n_idx   = '0;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_TRIG_LOW: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(TRIG_LOW_TICKS)) begin
                        n_phase = PH_TRIG_HIGH;
                        n_tick  = '0;
                    end
                end
                PH_TRIG_HIGH: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(TRIG_HIGH_TICKS)) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_WAIT: begin
                    if (i_echo) begin
                        n_phase = PH_MEASURE;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc;
                        if (tick_inc > i_cfg.lim_floor) begin
                            finished = 1'b1;
                            m_stat   = ST_NORESP;
                        end
                    end
                end
                PH_MEASURE: begin
                    if (!i_echo) begin
                        finished = 1'b1;
                        m_dist   = meas_dist;
                    end else begin
                        n_tick = tick_inc;
                        if (tick_inc >= i_cfg.lim_ceil) begin
                            finished = 1'b1;
                            if (tick_inc > i_cfg.lim_floor) begin
                                m_stat = ST_TIMEOUT;
                                m_dist = i_cfg.max_cm;
                            end else begin
                                m_dist = meas_dist;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        if (finished) begin
            n_tick = '0;
            if (!i_cfg.median || last_smp) begin
                n_idx   = '0;
                n_phase = PH_IDLE;
            end else begin
                n_idx   = k + IDX_W'(1);
                n_phase = PH_TRIG_LOW;
            end
        end
    end

    always_comb begin
        smp_wr.we      = i_step && finished && i_cfg.median;
        smp_wr.idx     = k;
        smp_wr.dist_cm = m_dist;
        smp_wr.stat    = m_stat;
    end

    uer_median u_median (
        .i_clk      (i_clk),
        .i_wr       (smp_wr),
        .o_sel_dist (sel_dist),
        .o_sel_stat (sel_stat)
    );

    // outputs
    always_comb begin
        o_res.trig    = (n_phase == PH_TRIG_HIGH);
        o_res.busy    = (n_phase != PH_IDLE);
        o_res.done    = 1'b0;
        o_res.dist_cm = '0;
        o_res.stat    = ST_OK;
        if (finished) begin
            if (!i_cfg.median) begin
                o_res.done    = 1'b1;
                o_res.dist_cm = m_dist;
                o_res.stat    = m_stat;
            end else if (last_smp) begin
                o_res.done    = 1'b1;
                o_res.dist_cm = sel_dist;
                o_res.stat    = sel_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> src/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// echo ranger top level: input word register, sequencer, output word register
// an accepted word waits in the input register until it can step, then its result word loads into the output register
// throughput: one word per cycle while result words are taken; input ready falls only while a result word waits
// echo limits are precomputed when the range register is written
// reset (synchronous, active low): idle, range 400, single mode; sample store not reset
module ultrasonic_echo_ranger (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // echo_level
    input  logic                             s_axis_tuser,   // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,   // trig_level, busy_res, done_res,
                                                             // distance_cm, status, zero pad
    input  logic                             i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import uer_pkg::*;

    logic    r_in_valid;
    logic    r_in_action;
    logic    r_in_echo;
    logic    r_out_valid;
    t_result r_out;
    logic    step;
    t_cfg    cfg;
    t_result res;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_echo   <= s_axis_tdata[0];
        end
    end

    uer_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    uer_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_action (r_in_action),
        .i_echo   (r_in_echo),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.stat, r_out.dist_cm, r_out.done, r_out.busy, r_out.trig};

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed word did not reach the output register");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> !r_out.busy)
        else $error("final result reported while still busy");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.trig) |-> r_out.busy)
        else $error("trigger driven while idle");

    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done) |-> (r_out.dist_cm == '0 && r_out.stat == ST_OK))
        else $error("result fields set without done");

endmodule

>>> tb/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the echo ranger: predictor and result scoreboard
module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam int unsigned LIMIT_SCALE = 20000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata   = 8'd0;  // echo_level, zero pad
    logic                  s_axis_tuser   = 1'b0;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [15:0]           m_axis_tdata;           // trig_level, busy_res, done_res,
                                                   // distance_cm, status, zero pad
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // predictor state and its copy of the registers
    logic [DIST_W-1:0]     cfg_max_cm;
    logic                  cfg_median;
    t_phase                rg_phase;
    logic [TICK_W-1:0]     rg_ticks;
    int                    rg_slot;
    logic [DIST_W-1:0]     smp_dist [MEDIAN_SAMPLES];
    logic [STAT_W-1:0]     smp_stat [MEDIAN_SAMPLES];

    t_result               cm_expected [$];
    int                    mismatch_count = 0;
    int                    words_sent     = 0;
    int                    quiet_cycles   = 0;
    int                    rdy_hold       = 0;
    bit                    idle_on        = 1'b1;

    ultrasonic_echo_ranger u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned limit_lo();
        return (int'(cfg_max_cm) * LIMIT_SCALE) / RANGE_DIV;
    endfunction

    function automatic logic [DIST_W-1:0] echo_cm(input logic [TICK_W-1:0] us);
        int unsigned p;
        p = 32'(us) * DIST_MUL;
        return DIST_W'(p >> DIST_SHIFT);
    endfunction

    function automatic int rank_key(input int i);
        return (smp_stat[i] == ST_NORESP) ? NORESP_KEY : int'(smp_dist[i]);
    endfunction

    function automatic t_result range_step(input logic act, input logic echo);
        t_result           r;
        logic              fin;
        logic [DIST_W-1:0] m_dist;
        logic [STAT_W-1:0] m_stat;
        int unsigned       lim_lo, lim_hi;
        int                k, mi, a, b, c;
        r      = '0;
        fin    = 1'b0;
        m_dist = '0;
        m_stat = ST_OK;
        lim_lo = limit_lo();
        lim_hi = ((int'(cfg_max_cm) * LIMIT_SCALE) % RANGE_DIV == 0) ? lim_lo : lim_lo + 1;
        if (act) begin
            if (rg_phase == PH_IDLE) begin
                rg_phase = PH_TRIG_LOW;
                rg_ticks = '0;
                rg_slot  = 0;
            end
        end else begin
            case (rg_phase)
                PH_TRIG_LOW: begin
                    rg_ticks = rg_ticks + 1'b1;
                    if (rg_ticks >= TRIG_LOW_TICKS) begin
                        rg_phase = PH_TRIG_HIGH;
                        rg_ticks = '0;
                    end
                end
                PH_TRIG_HIGH: begin
                    rg_ticks = rg_ticks + 1'b1;
                    if (rg_ticks >= TRIG_HIGH_TICKS) begin
                        rg_phase = PH_WAIT;
                        rg_ticks = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo) begin
                        rg_phase = PH_MEASURE;
                        rg_ticks = '0;
                    end else begin
                        rg_ticks = rg_ticks + 1'b1;
                        if (rg_ticks > lim_lo) begin
                            fin    = 1'b1;
                            m_stat = ST_NORESP;
                        end
                    end
                end
                PH_MEASURE: begin
                    if (!echo) begin
                        fin    = 1'b1;
                        m_dist = echo_cm(rg_ticks);
                    end else begin
                        rg_ticks = rg_ticks + 1'b1;
                        if (rg_ticks >= lim_hi) begin
                            fin = 1'b1;
                            if (rg_ticks > lim_lo) begin
                                m_stat = ST_TIMEOUT;
                                m_dist = cfg_max_cm;
                            end else begin
                                m_dist = echo_cm(rg_ticks);
                            end
                        end
                    end
                end
                default: rg_phase = PH_IDLE;
            endcase
        end

        if (fin) begin
            rg_ticks = '0;
            if (!cfg_median) begin
                r.done    = 1'b1;
                r.dist_cm = m_dist;
                r.stat    = m_stat;
                rg_slot   = 0;
                rg_phase  = PH_IDLE;
            end else begin
                k = (rg_slot < MEDIAN_SAMPLES) ? rg_slot : 0;
                smp_dist[k] = m_dist;
                smp_stat[k] = m_stat;
                if (k + 1 < MEDIAN_SAMPLES) begin
                    rg_slot  = k + 1;
                    rg_phase = PH_TRIG_LOW;
                end else begin
                    a = rank_key(0);
                    b = rank_key(1);
                    c = rank_key(2);
                    if (a <= b && a <= c)
                        mi = (b <= c) ? 1 : 2;
                    else if (b <= a && b <= c)
                        mi = (a <= c) ? 0 : 2;
                    else
                        mi = (a <= b) ? 0 : 1;
                    r.done    = 1'b1;
                    r.dist_cm = smp_dist[mi];
                    r.stat    = smp_stat[mi];
                    rg_slot   = 0;
                    rg_phase  = PH_IDLE;
                end
            end
        end
        r.trig = (rg_phase == PH_TRIG_HIGH);
        r.busy = (rg_phase != PH_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic send_word(input logic act, input logic echo);
        cm_expected.push_back(range_step(act, echo));
        words_sent++;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, echo};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        while (cm_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_words();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_DIST)
            cfg_max_cm = val;
        else
            cfg_median = val[0];
        repeat (2) @(posedge i_clk);
    endtask

    // one full sequence: start, trigger ticks, then echo shaped per measurement
    task automatic range_cycle(input int g0, input int p0, input int g1, input int p1,
                               input int g2, input int p2, input bit noisy);
        int gap [MEDIAN_SAMPLES];
        int pulse [MEDIAN_SAMPLES];
        int s;
        gap   = '{g0, g1, g2};
        pulse = '{p0, p1, p2};
        send_word(1'b1, 1'($urandom_range(0, 1)));
        while (rg_phase != PH_IDLE) begin
            s = (rg_slot < MEDIAN_SAMPLES) ? rg_slot : 0;
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(1'b1, 1'($urandom_range(0, 1)));
            else begin
                case (rg_phase)
                    PH_WAIT:    send_word(1'b0, rg_ticks >= gap[s]);
                    PH_MEASURE: send_word(1'b0, rg_ticks < pulse[s]);
                    default:    send_word(1'b0, 1'($urandom_range(0, 1)));
                endcase
            end
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int lim;
        int g [MEDIAN_SAMPLES];
        int p [MEDIAN_SAMPLES];
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            lim = int'(limit_lo());
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_word(1'b0, 1'($urandom_range(0, 1)));
            end else begin
                for (int i = 0; i < MEDIAN_SAMPLES; i++) begin
                    g[i] = ($urandom_range(0, 7) == 0) ? lim + $urandom_range(0, 2)
                                                       : $urandom_range(0, 8);
                    p[i] = ($urandom_range(0, 5) == 0) ? lim + $urandom_range(0, 3)
                                                       : $urandom_range(0, lim);
                end
                range_cycle(g[0], p[0], g[1], p[1], g[2], p[2], 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        range_cycle(3, 30, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_single_limits();
        write_reg(CFG_MAX_DIST, 10'd1);
        write_reg(CFG_MEDIAN, 10'h3FE);
        range_cycle(0, 0, 0, 0, 0, 0, 1'b0);
        range_cycle(2, 59, 0, 0, 0, 0, 1'b0);
        range_cycle(59, 1, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_zero_limit();
        write_reg(CFG_MAX_DIST, 10'd0);
        range_cycle(0, 0, 0, 0, 0, 0, 1'b0);
        range_cycle(0, 5, 0, 0, 0, 0, 1'b0);
        range_cycle(1, 0, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_median_ranking();
        write_reg(CFG_MAX_DIST, 10'd0);
        write_reg(CFG_MEDIAN, {9'($urandom_range(0, 511)), 1'b1});
        range_cycle(1, 0, 0, 5, 1, 0, 1'b0);
        range_cycle(0, 0, 1, 0, 0, 5, 1'b1);
        write_reg(CFG_MAX_DIST, 10'd1);
        range_cycle(0, 59, 0, 2, 0, 0, 1'b0);
        write_reg(CFG_MEDIAN, 10'd0);
        range_cycle(0, 3, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_random_sequences();
        repeat (2) begin
            write_reg(CFG_MAX_DIST, 10'($urandom_range(0, 1)));
            write_reg(CFG_MEDIAN, 10'($urandom_range(0, 1023)));
            random_traffic(40);
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_reg(CFG_MAX_DIST, 10'd1);
        write_reg(CFG_MEDIAN, 10'd1);
        random_traffic(50);
    endtask

    // result side stalls in random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rdy_hold = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cm_expected.size() == 0) begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = cm_expected.pop_front();
                check_field("trig_level", want.trig, m_axis_tdata[0]);
                check_field("busy_res", want.busy, m_axis_tdata[1]);
                check_field("done_res", want.done, m_axis_tdata[2]);
                check_field("distance_cm", want.dist_cm, m_axis_tdata[12:3]);
                check_field("status", want.stat, m_axis_tdata[14:13]);
                check_field("pad", 0, m_axis_tdata[15]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cfg_max_cm = DIST_W'(RESET_MAX_CM);
        cfg_median = 1'b0;
        rg_phase   = PH_IDLE;
        rg_ticks   = '0;
        rg_slot    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_single_limits();
        test_zero_limit();
        test_median_ranking();
        test_random_sequences();
        test_back_to_back();
        drain_words();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && cm_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
